@@ sv/hsm_pkg.sv @@
// ----------------------------------------------------------------------------
// hsm_pkg
// shared types, constants and checksum helpers for the two-wire sensor master
// ----------------------------------------------------------------------------
package hsm_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;

    // start pattern, bit i is tick i of the transmission start
    localparam logic [5:0] START_SCK = 6'b011011;
    localparam logic [5:0] START_DL  = 6'b001110;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONVERSION = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CRC_PRESET = 2'd2;

    localparam logic [7:0]  RELEASE_RESET    = 8'd255;
    localparam logic [19:0] CONVERSION_RESET = 20'd75000;
    localparam logic [7:0]  CRC_PRESET_RESET = 8'd0;

    localparam int IN_DATA_BITS  = 16;
    localparam int OUT_DATA_BITS = 24;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_ACK      = 3'd1,
        ST_RELEASE_TO  = 3'd2,
        ST_CONVERT_TO  = 3'd3,
        ST_CRC_ERROR   = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]  release_timeout;
        logic [19:0] conversion_timeout;
        logic [7:0]  crc_preset;
    } cfg_t;

    typedef struct packed {
        logic [15:0] word;
        status_t     status;
        logic        done_res;
        logic        busy_res;
        logic        data_low;
        logic        sck;
    } result_t;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] val);
        logic [7:0] c;
        logic [7:0] v;
        c = crc;
        v = val;
        for (int k = 0; k < 8; k++)
        begin
            if (v[7] ^ c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
            v = {v[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] reverse8(input logic [7:0] x);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[k] = x[7-k];
        end
        return r;
    endfunction

endpackage

@@ sv/humidity_sensor_two_wire_master_top.sv @@
// ----------------------------------------------------------------------------
// humidity_sensor_two_wire_master_top
// two-wire humidity sensor measurement master, one tick per transaction
// ----------------------------------------------------------------------------
// each input transaction is one half-bit tick: tuser = 1 requests a start
// (taken only when idle) with the command in tdata, and tdata also carries
// the sampled data line. every input gives exactly one output transaction
// with the clock level and data pull for that tick, busy/done flags, the
// status and, on a good finish, the 16-bit measured word.
// the input register feeds the sequencer, whose result lands in an output
// register, and one tick is taken every cycle when the output side keeps up.
// a stalled output holds its result; the input register still takes one more
// transaction, then tready drops until the output is taken.
// reset returns the sequencer to idle and loads the timeouts and checksum
// preset with their defaults; cfg writes take effect at once.
// ----------------------------------------------------------------------------
module humidity_sensor_two_wire_master_top #(
    parameter int TIMER_BITS = 20
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [hsm_pkg::IN_DATA_BITS-1:0]         s_tdata,   // cmd[7:0], data_pin[8]
    input  logic                                     s_tuser,   // op
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // sck[0], data_low[1], busy_res[2], done_res[3], status[6:4], word[22:7]
    output logic [hsm_pkg::OUT_DATA_BITS-1:0]        m_tdata,
    input  logic                                     cfg_we,
    input  logic [hsm_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [hsm_pkg::CFG_DATA_BITS-1:0]        cfg_data
);
    import hsm_pkg::*;

    logic       in_valid_reg;
    logic       op_reg;
    logic [7:0] cmd_reg;
    logic       pin_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    cfg_t       cfg_reg;
    result_t    res;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    hsm_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .op       (op_reg),
        .cmd      (cmd_reg),
        .data_pin (pin_reg),
        .cfg      (cfg_reg),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg               <= 1'b0;
            out_valid_reg              <= 1'b0;
            cfg_reg.release_timeout    <= RELEASE_RESET;
            cfg_reg.conversion_timeout <= CONVERSION_RESET;
            cfg_reg.crc_preset         <= CRC_PRESET_RESET;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RELEASE:    cfg_reg.release_timeout    <= cfg_data[7:0];
                    CFG_CONVERSION: cfg_reg.conversion_timeout <= cfg_data;
                    CFG_CRC_PRESET: cfg_reg.crc_preset         <= cfg_data[7:0];
                    default:        cfg_reg                    <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg  <= s_tuser;
            cmd_reg <= s_tdata[7:0];
            pin_reg <= s_tdata[8];
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

endmodule

@@ sv/hsm_core.sv @@
// ----------------------------------------------------------------------------
// hsm_core
// per-tick sequencer: start pattern, command, ack, waits, reads and checksum
// ----------------------------------------------------------------------------
module hsm_core #(
    parameter int TIMER_BITS = 20
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            op,
    input  logic [7:0]      cmd,
    input  logic            data_pin,
    input  hsm_pkg::cfg_t    cfg,
    output hsm_pkg::result_t res
);
    import hsm_pkg::*;

    localparam int WB = ((TIMER_BITS > 20) ? TIMER_BITS : 20) + 1;
    localparam logic [WB-1:0] MAX_COUNT = WB'((64'd1 << TIMER_BITS) - 64'd1);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_CMD,
        PH_ACKLO,
        PH_ACKHI,
        PH_REL,
        PH_CONV,
        PH_RD,
        PH_AK
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [3:0]            bit_count_reg, bit_count_next;
    logic [1:0]            byte_idx_reg, byte_idx_next;
    logic [7:0]            shift_byte_reg, shift_byte_next;
    logic [7:0]            command_hold_reg, command_hold_next;
    logic [15:0]           received_word_reg, received_word_next;
    logic [7:0]            running_crc_reg, running_crc_next;
    logic [TIMER_BITS-1:0] wait_count_reg, wait_count_next;

    logic [WB-1:0] wait_inc;
    logic          release_expired;
    logic          convert_expired;
    logic [2:0]    start_idx;
    logic [7:0]    shift_in;

    assign wait_inc        = WB'(wait_count_reg) + WB'(1);
    assign release_expired = (wait_inc >= WB'(cfg.release_timeout)) || (wait_inc >= MAX_COUNT);
    assign convert_expired = (wait_inc >= WB'(cfg.conversion_timeout))
                             || (wait_inc >= MAX_COUNT);
    assign start_idx       = (bit_count_reg < 4'd6) ? bit_count_reg[2:0] : 3'd5;
    assign shift_in        = bit_count_reg[0] ? {shift_byte_reg[6:0], data_pin} : shift_byte_reg;

    always_comb
    begin
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        byte_idx_next      = byte_idx_reg;
        shift_byte_next    = shift_byte_reg;
        command_hold_next  = command_hold_reg;
        received_word_next = received_word_reg;
        running_crc_next   = running_crc_reg;
        wait_count_next    = wait_count_reg;
        res                = '0;
        res.status         = ST_OK;
        res.busy_res       = 1'b1;

        case (phase_reg)
            PH_IDLE:
            begin
                if (op)
                begin
                    command_hold_next  = cmd;
                    running_crc_next   = crc_feed(cfg.crc_preset, cmd);
                    received_word_next = '0;
                    shift_byte_next    = '0;
                    wait_count_next    = '0;
                    bit_count_next     = 4'd1;
                    phase_next         = PH_START;
                    res.sck            = 1'b1;
                end
                else
                begin
                    res.busy_res = 1'b0;
                end
            end
            PH_START:
            begin
                res.sck      = START_SCK[start_idx];
                res.data_low = START_DL[start_idx];
                if (start_idx >= 3'd5)
                begin
                    phase_next     = PH_CMD;
                    bit_count_next = '0;
                end
                else
                begin
                    bit_count_next = {1'b0, start_idx} + 4'd1;
                end
            end
            PH_CMD:
            begin
                res.sck      = bit_count_reg[0];
                res.data_low = ~command_hold_reg[3'd7 - bit_count_reg[3:1]];
                if (bit_count_reg == 4'd15)
                begin
                    phase_next     = PH_ACKLO;
                    bit_count_next = '0;
                end
                else
                begin
                    bit_count_next = bit_count_reg + 4'd1;
                end
            end
            PH_ACKLO:
            begin
                phase_next = PH_ACKHI;
            end
            PH_ACKHI:
            begin
                res.sck = 1'b1;
                if (data_pin)
                begin
                    res.done_res = 1'b1;
                    res.status   = ST_NO_ACK;
                    phase_next   = PH_IDLE;
                end
                else
                begin
                    phase_next      = PH_REL;
                    wait_count_next = '0;
                end
            end
            PH_REL:
            begin
                if (data_pin)
                begin
                    phase_next      = PH_CONV;
                    wait_count_next = '0;
                end
                else if (release_expired)
                begin
                    res.done_res = 1'b1;
                    res.status   = ST_RELEASE_TO;
                    phase_next   = PH_IDLE;
                end
                else
                begin
                    wait_count_next = wait_inc[TIMER_BITS-1:0];
                end
            end
            PH_CONV:
            begin
                if (!data_pin)
                begin
                    phase_next      = PH_RD;
                    byte_idx_next   = '0;
                    bit_count_next  = '0;
                    shift_byte_next = '0;
                end
                else if (convert_expired)
                begin
                    res.done_res = 1'b1;
                    res.status   = ST_CONVERT_TO;
                    phase_next   = PH_IDLE;
                end
                else
                begin
                    wait_count_next = wait_inc[TIMER_BITS-1:0];
                end
            end
            PH_RD:
            begin
                res.sck         = bit_count_reg[0];
                shift_byte_next = shift_in;
                if (bit_count_reg == 4'd15)
                begin
                    if (byte_idx_reg == 2'd0)
                    begin
                        received_word_next = {shift_in, received_word_reg[7:0]};
                    end
                    else if (byte_idx_reg == 2'd1)
                    begin
                        received_word_next = {received_word_reg[15:8], shift_in};
                    end
                    if (byte_idx_reg != 2'd2)
                    begin
                        running_crc_next = crc_feed(running_crc_reg, shift_in);
                    end
                    phase_next     = PH_AK;
                    bit_count_next = '0;
                end
                else
                begin
                    bit_count_next = bit_count_reg + 4'd1;
                end
            end
            PH_AK:
            begin
                if (bit_count_reg < 4'd2)
                begin
                    res.sck        = bit_count_reg[0];
                    res.data_low   = (byte_idx_reg != 2'd2);
                    bit_count_next = bit_count_reg + 4'd1;
                end
                else if (byte_idx_reg != 2'd2)
                begin
                    phase_next      = PH_RD;
                    byte_idx_next   = byte_idx_reg + 2'd1;
                    bit_count_next  = '0;
                    shift_byte_next = '0;
                end
                else
                begin
                    res.done_res   = 1'b1;
                    phase_next     = PH_IDLE;
                    bit_count_next = '0;
                    if (reverse8(running_crc_reg) == shift_byte_reg)
                    begin
                        res.status = ST_OK;
                        res.word   = received_word_reg;
                    end
                    else
                    begin
                        res.status = ST_CRC_ERROR;
                    end
                end
            end
            default:
            begin
                phase_next   = PH_IDLE;
                res.busy_res = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bit_count_reg     <= '0;
            byte_idx_reg      <= '0;
            shift_byte_reg    <= '0;
            command_hold_reg  <= '0;
            received_word_reg <= '0;
            running_crc_reg   <= '0;
            wait_count_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            bit_count_reg     <= bit_count_next;
            byte_idx_reg      <= byte_idx_next;
            shift_byte_reg    <= shift_byte_next;
            command_hold_reg  <= command_hold_next;
            received_word_reg <= received_word_next;
            running_crc_reg   <= running_crc_next;
            wait_count_reg    <= wait_count_next;
        end
    end

    a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.done_res |=> phase_reg == PH_IDLE)
        else $error("sequencer did not return to idle after finishing");

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_IDLE && op |=> phase_reg == PH_START && bit_count_reg == 4'd1)
        else $error("start request did not begin the start pattern");

    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(bit_count_reg) && $stable(wait_count_reg))
        else $error("sequencer state moved without a tick");

    a_checksum_finish: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_AK && byte_idx_reg == 2'd2 && bit_count_reg == 4'd2 |-> res.done_res)
        else $error("checksum byte did not finish the transaction");

    a_word_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res.word != 16'd0 |-> res.done_res && res.status == ST_OK)
        else $error("word given without a good finish");

endmodule

@@ tb/tb_humidity_sensor_two_wire_master_top.sv @@
// ----------------------------------------------------------------------------
// tb_humidity_sensor_two_wire_master_top
// self-checking bench for the two-wire humidity sensor measurement master
// ----------------------------------------------------------------------------
// ticks go in one stream transaction at a time. A behavioral model of the
// sequencer predicts the output of every tick when it is accepted. A small
// sensor model picks the sampled data pin from the predicted sequencer state,
// so that most measurements run through ack, both waits, the reads and the
// checksum. Directed tests cover idle ticks, no ack, both timeouts at their
// limits, good and bad checksums and the register extremes. Then random
// measurements run under several register settings. Both stream sides pause
// at random.
// ----------------------------------------------------------------------------
module tb_humidity_sensor_two_wire_master_top;

    import hsm_pkg::*;

    localparam int TIMER_BITS = 20;
    localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_BITS) - 1;
    localparam logic [5:0] START_CLK  = 6'b011011;
    localparam logic [5:0] START_PULL = 6'b001110;
    localparam int RANDOM_TICKS = 200;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_CMD,
        SEQ_ACK_LO,
        SEQ_ACK_HI,
        SEQ_RELEASE,
        SEQ_CONVERT,
        SEQ_READ,
        SEQ_TRAIL
    } seq_phase_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_DATA_BITS-1:0]   s_tdata;   // cmd[7:0], data_pin[8]
    logic                      s_tuser;   // op
    logic                      m_tvalid;
    logic                      m_tready;
    // sck[0], data_low[1], busy_res[2], done_res[3], status[6:4], word[22:7]
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic                      cfg_we;
    logic [CFG_IDX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // sequencer model state and register copies
    seq_phase_t        seq_phase;
    logic [3:0]        seq_count;
    logic [7:0]        shift_reg;
    logic [7:0]        cmd_latched;
    logic [15:0]       word_acc;
    logic [7:0]        crc_acc;
    longint unsigned   wait_ticks;
    int unsigned       byte_sel;
    logic [7:0]        rel_limit;
    logic [19:0]       conv_limit;
    logic [7:0]        crc_seed;

    result_t           tick_results[$];
    result_t           want_result;
    result_t           seen_result;
    int unsigned       mismatch_count;
    int unsigned       busy_ticks;
    int unsigned       idle_pct;
    int unsigned       stall_pct;

    humidity_sensor_two_wire_master_top #(
        .TIMER_BITS (TIMER_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ data[i];
            c = {c[6:0], 1'b0};
            if (fb)
            begin
                c = c ^ 8'h31;
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] bit_reverse(input logic [7:0] x);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = x[7 - i];
        end
        return r;
    endfunction

    function automatic void reset_sequencer();
        seq_phase   = SEQ_IDLE;
        seq_count   = '0;
        shift_reg   = '0;
        cmd_latched = '0;
        word_acc    = '0;
        crc_acc     = '0;
        wait_ticks  = 0;
        byte_sel    = 0;
        rel_limit   = 8'd255;
        conv_limit  = 20'd75000;
        crc_seed    = 8'd0;
    endfunction

    // counts one wait sample, true when the wait has run out
    function automatic bit wait_expired(input longint unsigned limit);
        longint unsigned next_count;
        next_count = wait_ticks + 1;
        if (next_count >= limit || next_count >= TIMER_MAX)
        begin
            return 1'b1;
        end
        wait_ticks = next_count;
        return 1'b0;
    endfunction

    function automatic result_t step_sequencer(input logic op, input logic [7:0] cmd,
                                               input logic pin);
        result_t     r;
        int unsigned b;
        r = '0;
        r.status = ST_OK;
        r.busy_res = 1'b1;
        b = 32'(seq_count);
        case (seq_phase)
            SEQ_IDLE:
            begin
                if (op)
                begin
                    cmd_latched = cmd;
                    crc_acc = crc8_update(crc_seed, cmd);
                    word_acc = '0;
                    shift_reg = '0;
                    wait_ticks = 0;
                    seq_count = 4'd1;
                    seq_phase = SEQ_START;
                    r.sck = 1'b1;
                end
                else
                begin
                    r.busy_res = 1'b0;
                end
            end
            SEQ_START:
            begin
                if (b > 5)
                begin
                    b = 5;
                end
                r.sck = START_CLK[b];
                r.data_low = START_PULL[b];
                if (b == 5)
                begin
                    seq_phase = SEQ_CMD;
                    seq_count = '0;
                end
                else
                begin
                    seq_count = 4'(b + 1);
                end
            end
            SEQ_CMD:
            begin
                r.sck = seq_count[0];
                r.data_low = ~cmd_latched[7 - (b >> 1)];
                if (b == 15)
                begin
                    seq_phase = SEQ_ACK_LO;
                    seq_count = '0;
                end
                else
                begin
                    seq_count = 4'(b + 1);
                end
            end
            SEQ_ACK_LO:
            begin
                seq_phase = SEQ_ACK_HI;
            end
            SEQ_ACK_HI:
            begin
                r.sck = 1'b1;
                if (pin)
                begin
                    r.done_res = 1'b1;
                    r.status = ST_NO_ACK;
                    seq_phase = SEQ_IDLE;
                end
                else
                begin
                    seq_phase = SEQ_RELEASE;
                    wait_ticks = 0;
                end
            end
            SEQ_RELEASE:
            begin
                if (pin)
                begin
                    seq_phase = SEQ_CONVERT;
                    wait_ticks = 0;
                end
                else if (wait_expired(64'(rel_limit)))
                begin
                    r.done_res = 1'b1;
                    r.status = ST_RELEASE_TO;
                    seq_phase = SEQ_IDLE;
                end
            end
            SEQ_CONVERT:
            begin
                if (!pin)
                begin
                    seq_phase = SEQ_READ;
                    byte_sel = 0;
                    seq_count = '0;
                    shift_reg = '0;
                end
                else if (wait_expired(64'(conv_limit)))
                begin
                    r.done_res = 1'b1;
                    r.status = ST_CONVERT_TO;
                    seq_phase = SEQ_IDLE;
                end
            end
            SEQ_READ:
            begin
                r.sck = seq_count[0];
                if (r.sck)
                begin
                    shift_reg = {shift_reg[6:0], pin};
                end
                if (b == 15)
                begin
                    if (byte_sel == 0)
                    begin
                        word_acc[15:8] = shift_reg;
                    end
                    else if (byte_sel == 1)
                    begin
                        word_acc[7:0] = shift_reg;
                    end
                    if (byte_sel < 2)
                    begin
                        crc_acc = crc8_update(crc_acc, shift_reg);
                    end
                    seq_phase = SEQ_TRAIL;
                    seq_count = '0;
                end
                else
                begin
                    seq_count = 4'(b + 1);
                end
            end
            SEQ_TRAIL:
            begin
                if (b < 2)
                begin
                    r.sck = seq_count[0];
                    r.data_low = (byte_sel < 2);
                    seq_count = 4'(b + 1);
                end
                else if (byte_sel < 2)
                begin
                    seq_phase = SEQ_READ;
                    byte_sel = byte_sel + 1;
                    seq_count = '0;
                    shift_reg = '0;
                end
                else
                begin
                    r.done_res = 1'b1;
                    seq_phase = SEQ_IDLE;
                    seq_count = '0;
                    if (bit_reverse(crc_acc) == shift_reg)
                    begin
                        r.word = word_acc;
                    end
                    else
                    begin
                        r.status = ST_CRC_ERROR;
                    end
                end
            end
            default:
            begin
                seq_phase = SEQ_IDLE;
                r.busy_res = 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic send_tick(input logic op, input logic [7:0] cmd, input logic pin);
        result_t r;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, pin, cmd};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        r = step_sequencer(op, cmd, pin);
        if (r.busy_res)
        begin
            busy_ticks++;
        end
        tick_results.push_back(r);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tick_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apply_settings(input logic [7:0] rel, input logic [19:0] conv,
                                  input logic [7:0] seed);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RELEASE;
        cfg_data  <= {12'b0, rel};
        @(posedge clk);
        cfg_index <= CFG_CONVERSION;
        cfg_data  <= conv;
        @(posedge clk);
        cfg_index <= CFG_CRC_PRESET;
        cfg_data  <= {12'b0, seed};
        @(posedge clk);
        cfg_we    <= 1'b0;
        rel_limit  = rel;
        conv_limit = conv;
        crc_seed   = seed;
    endtask

    // one start plus ticks until the sequencer is idle again, the pin follows a sensor that
    // acks or not as ack says, waits, converts and returns the bytes, or is random when noisy
    task automatic run_measurement(input logic [7:0] cmd, input bit ack,
                                   input int unsigned rel_lows, input int unsigned conv_highs,
                                   input logic [7:0] hi_byte, input logic [7:0] lo_byte,
                                   input bit crc_good, input bit noisy);
        logic [7:0]  frame [3];
        int unsigned rel_seen;
        int unsigned conv_seen;
        logic        pin;
        frame[0] = hi_byte;
        frame[1] = lo_byte;
        frame[2] = 8'($urandom);
        if (crc_good)
        begin
            frame[2] = bit_reverse(crc8_update(crc8_update(crc8_update(crc_seed, cmd),
                                                           hi_byte), lo_byte));
        end
        rel_seen = 0;
        conv_seen = 0;
        send_tick(1'b1, cmd, 1'($urandom_range(0, 1)));
        while (seq_phase != SEQ_IDLE)
        begin
            pin = 1'($urandom_range(0, 1));
            if (!noisy)
            begin
                case (seq_phase)
                    SEQ_ACK_HI:
                    begin
                        pin = !ack;
                    end
                    SEQ_RELEASE:
                    begin
                        pin = (rel_seen >= rel_lows);
                        rel_seen++;
                    end
                    SEQ_CONVERT:
                    begin
                        pin = (conv_seen < conv_highs);
                        conv_seen++;
                    end
                    SEQ_READ:
                    begin
                        if (seq_count[0])
                        begin
                            pin = frame[byte_sel][7 - (seq_count >> 1)];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            // a start while busy must be ignored
            send_tick($urandom_range(0, 4) == 0, 8'($urandom), pin);
        end
    endtask

    task automatic test_idle_ticks();
        send_tick(1'b0, 8'h00, 1'b0);
        send_tick(1'b0, 8'hff, 1'b1);
        send_tick(1'b0, 8'ha5, 1'b0);
        send_tick(1'b0, 8'h5a, 1'b1);
    endtask

    task automatic test_no_ack();
        run_measurement(8'hff, 1'b0, 0, 0, 8'h00, 8'h00, 1'b1, 1'b0);
    endtask

    task automatic test_default_measurement();
        run_measurement(8'h03, 1'b1, 3, 10, 8'hff, 8'h00, 1'b1, 1'b0);
        // long stretch with no pauses on either side
        idle_pct  = 0;
        stall_pct = 0;
        run_measurement(8'h05, 1'b1, 254, 1, 8'h12, 8'h34, 1'b1, 1'b0);
        idle_pct  = 28;
        stall_pct = 28;
    endtask

    task automatic test_release_timeout();
        apply_settings(8'd1, 20'd75000, 8'h00);
        run_measurement(8'h03, 1'b1, 4, 0, 8'h00, 8'h00, 1'b1, 1'b0);
        apply_settings(8'd6, 20'd75000, 8'h00);
        run_measurement(8'h03, 1'b1, 6, 0, 8'h00, 8'h00, 1'b1, 1'b0);
    endtask

    task automatic test_conversion_timeout();
        apply_settings(8'd8, 20'd1, 8'h5a);
        run_measurement(8'h05, 1'b1, 2, 3, 8'h00, 8'h00, 1'b1, 1'b0);
        apply_settings(8'd8, 20'd6, 8'h5a);
        run_measurement(8'h05, 1'b1, 0, 6, 8'h00, 8'h00, 1'b1, 1'b0);
        apply_settings(8'd8, 20'hfffff, 8'h5a);
        run_measurement(8'h07, 1'b1, 1, 20, 8'h80, 8'h01, 1'b1, 1'b0);
    endtask

    task automatic test_checksum();
        apply_settings(8'd16, 20'd64, 8'hff);
        run_measurement(8'h00, 1'b1, 1, 2, 8'h00, 8'hff, 1'b1, 1'b0);
        run_measurement(8'h1f, 1'b1, 1, 2, 8'hc3, 8'h3c, 1'b0, 1'b0);
    endtask

    task automatic test_random_measurements();
        int unsigned first_tick;
        int unsigned round;
        int unsigned rel_lows;
        int unsigned conv_highs;
        logic [7:0]  rel;
        logic [19:0] conv;
        first_tick = busy_ticks;
        round = 0;
        rel = 8'd1;
        conv = 20'd1;
        while (busy_ticks - first_tick < RANDOM_TICKS)
        begin
            if (round % 2 == 0)
            begin
                rel  = 8'($urandom_range(1, 12));
                conv = 20'($urandom_range(1, 40));
                apply_settings(rel, conv, 8'($urandom));
            end
            rel_lows = ($urandom_range(0, 3) == 0) ? $urandom_range(0, rel + 2)
                                                   : $urandom_range(0, rel - 1);
            conv_highs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, conv + 2)
                                                     : $urandom_range(0, conv - 1);
            run_measurement(8'($urandom), $urandom_range(0, 9) != 0, rel_lows, conv_highs,
                            8'($urandom), 8'($urandom), $urandom_range(0, 4) != 0,
                            $urandom_range(0, 9) == 0);
            repeat ($urandom_range(0, 2))
            begin
                send_tick(1'b0, 8'($urandom), 1'($urandom_range(0, 1)));
            end
            round++;
        end
    endtask

    task automatic note_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("mismatch in %s: expected %0h, got %0h", field, want, got);
        end
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        m_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tick_results.size() == 0)
            begin
                note_mismatch("unexpected output transaction", 64'd0, 64'(m_tdata));
            end
            else
            begin
                want_result = tick_results.pop_front();
                seen_result = result_t'(m_tdata[22:0]);
                if (seen_result.sck !== want_result.sck)
                    note_mismatch("sck", 64'(want_result.sck), 64'(seen_result.sck));
                if (seen_result.data_low !== want_result.data_low)
                    note_mismatch("data_low", 64'(want_result.data_low),
                                  64'(seen_result.data_low));
                if (seen_result.busy_res !== want_result.busy_res)
                    note_mismatch("busy_res", 64'(want_result.busy_res),
                                  64'(seen_result.busy_res));
                if (seen_result.done_res !== want_result.done_res)
                    note_mismatch("done_res", 64'(want_result.done_res),
                                  64'(seen_result.done_res));
                if (seen_result.status !== want_result.status)
                    note_mismatch("status", 64'(want_result.status), 64'(seen_result.status));
                if (seen_result.word !== want_result.word)
                    note_mismatch("word", 64'(want_result.word), 64'(seen_result.word));
                if (m_tdata[23] !== 1'b0)
                    note_mismatch("tdata padding", 64'd0, 64'(m_tdata[23]));
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_RELEASE;
        cfg_data  <= '0;
        reset_sequencer();
        mismatch_count = 0;
        busy_ticks = 0;
        idle_pct = 28;
        stall_pct = 28;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_ticks();
        test_no_ack();
        test_default_measurement();
        test_release_timeout();
        test_conversion_timeout();
        test_checksum();
        test_random_measurements();
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
sv/hsm_pkg.sv
sv/hsm_core.sv
sv/humidity_sensor_two_wire_master_top.sv
tb/tb_humidity_sensor_two_wire_master_top.sv
